[hw/rtl/ddct_pkg.sv]
// Package: constants, types and helpers for the drift-diffusion confidence trial block.
package ddct_pkg;

	localparam int MAX_STEPS = 16384;
	localparam int CNT_W     = $clog2(MAX_STEPS + 1);
	localparam int STEPS_W   = 15;
	localparam int NOISE_W   = 24;
	localparam int EV_W      = 32;
	localparam int WIDE_W    = 34;
	localparam int CMP_W     = 36;
	localparam int ADDR_W    = 5;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 40;

	typedef enum logic [2:0] {
		REG_BOUND_A         = 3'd0,
		REG_DRIFT_STEP      = 3'd1,
		REG_COLLAPSE_STEP   = 3'd2,
		REG_CONF_BOUND      = 3'd3,
		REG_POST_DRIFT_STEP = 3'd4,
		REG_CONF_UP_COLL    = 3'd5,
		REG_CONF_LO_COLL    = 3'd6,
		REG_CONF_START      = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		PH_NEW  = 2'd0,
		PH_DEC  = 2'd1,
		PH_CONF = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		OUT_ERROR   = 2'd0,
		OUT_CORRECT = 2'd1,
		OUT_TIMEOUT = 2'd2
	} outcome_t;

	localparam logic [30:0] BOUND_A_RST   = 31'd65536;
	localparam logic [23:0] DRIFT_RST     = 24'd66;
	localparam logic [22:0] COLLAPSE_RST  = 23'd0;
	localparam logic [30:0] CONF_BOUND_RST = 31'd65536;
	localparam logic [23:0] POST_DRIFT_RST = 24'd66;
	localparam logic [30:0] CONF_START_RST = 31'd32768;

	function automatic logic signed [EV_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
		logic signed [WIDE_W-1:0] hi;
		logic signed [WIDE_W-1:0] lo;
		hi = WIDE_W'(34'sh0_7FFF_FFFF);
		lo = -hi - WIDE_W'(34'sd1);
		if (v > hi) begin
			sat32 = {1'b0, {(EV_W-1){1'b1}}};
		end else if (v < lo) begin
			sat32 = {1'b1, {(EV_W-1){1'b0}}};
		end else begin
			sat32 = v[EV_W-1:0];
		end
	endfunction

endpackage

[hw/rtl/drift_diffusion_confidence_trial.sv]
// Top level: two-phase drift-diffusion trial with collapsing bounds and confidence rating.
//
//  channel   | dir | handshake               | payload
//  s_axis    | in  | s_tvalid / s_tready     | s_tdata[23:0] noise_step
//  m_axis    | out | m_tvalid / m_tready     | m_tdata: steps, outcome, conf steps, high, level
//  apb       | in  | psel, penable, pready   | paddr[4:2] register, pwdata / prdata
//
// One noise item per cycle while the output is not stalled: an input register feeds
// a single add-saturate-compare step, the trial result lands in a second register and
// the confidence levels are formed into the output register.
// Reset clears the trial state and loads the register defaults; no clearing pass.
// A stalled output holds the pipe; input is taken while any stage can still move.
module drift_diffusion_confidence_trial (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [23:0] noise_step
	input  logic [ddct_pkg::IN_TDATA_W-1:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [14:0] decision_steps, [16:15] outcome, [31:17] confidence_steps,
	// [32] confidence_high, [35:33] confidence_level, [39:36] zero
	output logic [ddct_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [ddct_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CW = ddct_pkg::CNT_W;
	localparam int WW = ddct_pkg::WIDE_W;
	localparam int EW = ddct_pkg::EV_W;
	localparam int KW = ddct_pkg::CMP_W;

	// configuration
	logic [30:0] bound_a_q, conf_bound_q, conf_start_q;
	logic [23:0] drift_step_q, post_drift_q;
	logic [22:0] collapse_q, conf_up_coll_q, conf_lo_coll_q;

	ddct_pkg::reg_idx_t cfg_idx;
	assign cfg_idx = ddct_pkg::reg_idx_t'(paddr[4:2]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bound_a_q      <= ddct_pkg::BOUND_A_RST;
			drift_step_q   <= ddct_pkg::DRIFT_RST;
			collapse_q     <= ddct_pkg::COLLAPSE_RST;
			conf_bound_q   <= ddct_pkg::CONF_BOUND_RST;
			post_drift_q   <= ddct_pkg::POST_DRIFT_RST;
			conf_up_coll_q <= ddct_pkg::COLLAPSE_RST;
			conf_lo_coll_q <= ddct_pkg::COLLAPSE_RST;
			conf_start_q   <= ddct_pkg::CONF_START_RST;
		end else if (psel && penable && pwrite) begin
			unique case (cfg_idx)
				ddct_pkg::REG_BOUND_A:         bound_a_q      <= pwdata[30:0];
				ddct_pkg::REG_DRIFT_STEP:      drift_step_q   <= pwdata[23:0];
				ddct_pkg::REG_COLLAPSE_STEP:   collapse_q     <= pwdata[22:0];
				ddct_pkg::REG_CONF_BOUND:      conf_bound_q   <= pwdata[30:0];
				ddct_pkg::REG_POST_DRIFT_STEP: post_drift_q   <= pwdata[23:0];
				ddct_pkg::REG_CONF_UP_COLL:    conf_up_coll_q <= pwdata[22:0];
				ddct_pkg::REG_CONF_LO_COLL:    conf_lo_coll_q <= pwdata[22:0];
				ddct_pkg::REG_CONF_START:      conf_start_q   <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			ddct_pkg::REG_BOUND_A:         prdata = {1'b0, bound_a_q};
			ddct_pkg::REG_DRIFT_STEP:      prdata = {8'd0, drift_step_q};
			ddct_pkg::REG_COLLAPSE_STEP:   prdata = {9'd0, collapse_q};
			ddct_pkg::REG_CONF_BOUND:      prdata = {1'b0, conf_bound_q};
			ddct_pkg::REG_POST_DRIFT_STEP: prdata = {8'd0, post_drift_q};
			ddct_pkg::REG_CONF_UP_COLL:    prdata = {9'd0, conf_up_coll_q};
			ddct_pkg::REG_CONF_LO_COLL:    prdata = {9'd0, conf_lo_coll_q};
			ddct_pkg::REG_CONF_START:      prdata = {1'b0, conf_start_q};
			default:                       prdata = 32'd0;
		endcase
	end

	// pipeline control
	logic        v_s1, v_s2;
	logic [23:0] noise_s1;
	logic        out_free, adv_s2, load_s2, adv_s1;

	assign out_free = !m_tvalid || m_tready;
	assign adv_s2   = v_s2 && out_free;
	assign load_s2  = !v_s2 || adv_s2;
	assign adv_s1   = v_s1 && load_s2;
	assign s_tready = !v_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			noise_s1 <= s_tdata;
		end
	end

	// trial state
	ddct_pkg::phase_t          phase_q, phase_nx;
	logic signed [EW-1:0]      ev_q, up_q, lo_q;
	logic [CW-1:0]             cnt_q;
	logic [CW-1:0]             held_ds_q;
	ddct_pkg::outcome_t        held_out_q;

	logic                      in_dec;
	logic signed [EW-1:0]      st_e, st_up, st_lo;
	logic [CW-1:0]             st_cnt, cnt1;
	logic signed [WW-1:0]      drift_w, noise_w, cu_w, cl_w;
	logic signed [EW-1:0]      sum_e, nu, nl;
	logic signed [EW-1:0]      cs_e, cb_e;
	logic                      tmo, dec_done, cs_in, conf_done, emit;
	ddct_pkg::outcome_t        res;

	always_comb begin
		in_dec = (phase_q != ddct_pkg::PH_CONF);
		if (phase_q == ddct_pkg::PH_DEC || phase_q == ddct_pkg::PH_CONF) begin
			st_e   = ev_q;
			st_up  = up_q;
			st_lo  = lo_q;
			st_cnt = cnt_q;
		end else begin
			st_e   = EW'({1'b0, bound_a_q[30:1]});
			st_up  = EW'({1'b0, bound_a_q});
			st_lo  = '0;
			st_cnt = '0;
		end
		noise_w = WW'($signed(noise_s1));
		if (in_dec) begin
			drift_w = WW'($signed(drift_step_q));
			cu_w    = WW'({1'b0, collapse_q});
			cl_w    = WW'({1'b0, collapse_q});
		end else begin
			drift_w = (held_out_q == ddct_pkg::OUT_ERROR) ? -WW'($signed(post_drift_q))
			                                               :  WW'($signed(post_drift_q));
			cu_w    = WW'({1'b0, conf_up_coll_q});
			cl_w    = WW'({1'b0, conf_lo_coll_q});
		end
		cnt1  = st_cnt + CW'(1);
		sum_e = ddct_pkg::sat32(WW'(st_e) + drift_w + noise_w);
		nu    = ddct_pkg::sat32(WW'(st_up) - cu_w);
		nl    = ddct_pkg::sat32(WW'(st_lo) + cl_w);
		tmo   = (cnt1 >= CW'(ddct_pkg::MAX_STEPS));

		if (sum_e >= nu) begin
			res = ddct_pkg::OUT_CORRECT;
		end else if (sum_e <= nl) begin
			res = ddct_pkg::OUT_ERROR;
		end else begin
			res = ddct_pkg::OUT_TIMEOUT;
		end
		dec_done  = (sum_e >= nu) || (sum_e <= nl) || tmo;

		cs_e      = EW'({1'b0, conf_start_q});
		cb_e      = EW'({1'b0, conf_bound_q});
		cs_in     = (cs_e < cb_e) && (cs_e > EW'(0));
		conf_done = tmo || !((sum_e < nu) && (sum_e > nl));
		emit      = in_dec ? (dec_done && !cs_in) : conf_done;
	end

	always_comb begin
		unique case (phase_q)
			ddct_pkg::PH_CONF: phase_nx = conf_done ? ddct_pkg::PH_NEW : ddct_pkg::PH_CONF;
			default: begin
				if (!dec_done) begin
					phase_nx = ddct_pkg::PH_DEC;
				end else begin
					phase_nx = cs_in ? ddct_pkg::PH_CONF : ddct_pkg::PH_NEW;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= ddct_pkg::PH_NEW;
			ev_q       <= '0;
			up_q       <= '0;
			lo_q       <= '0;
			cnt_q      <= '0;
			held_ds_q  <= '0;
			held_out_q <= ddct_pkg::OUT_ERROR;
		end else if (adv_s1) begin
			phase_q <= phase_nx;
			if (in_dec && dec_done) begin
				held_ds_q  <= cnt1;
				held_out_q <= res;
				ev_q       <= cs_e;
				up_q       <= cb_e;
				lo_q       <= '0;
				cnt_q      <= '0;
			end else begin
				ev_q  <= sum_e;
				up_q  <= nu;
				lo_q  <= nl;
				cnt_q <= cnt1;
			end
		end
	end

	// trial result
	logic [ddct_pkg::STEPS_W-1:0] ds_s2, cs_s2;
	ddct_pkg::outcome_t           out_s2;
	logic signed [EW-1:0]         e_s2;
	logic [30:0]                  a2_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (load_s2) begin
			v_s2 <= adv_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2 && adv_s1 && emit) begin
			a2_s2 <= conf_bound_q;
			if (in_dec) begin
				ds_s2  <= ddct_pkg::STEPS_W'(cnt1);
				out_s2 <= res;
				cs_s2  <= '0;
				e_s2   <= cs_e;
			end else begin
				ds_s2  <= ddct_pkg::STEPS_W'(held_ds_q);
				out_s2 <= held_out_q;
				cs_s2  <= ddct_pkg::STEPS_W'(cnt1);
				e_s2   <= sum_e;
			end
		end
	end

	// confidence rating
	logic signed [KW-1:0] e_x, six_e, two_e, a2_x;
	logic                 high_c;
	logic [2:0]           level_c;

	always_comb begin
		e_x     = KW'(e_s2);
		a2_x    = KW'({1'b0, a2_s2});
		six_e   = (e_x <<< 2) + (e_x <<< 1);
		two_e   = e_x <<< 1;
		high_c  = (two_e >= a2_x);
		level_c = 3'd6;
		for (int k = 5; k >= 1; k--) begin
			if (six_e < a2_x * KW'(k)) begin
				level_c = 3'(k);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_free) begin
			m_tvalid <= adv_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			m_tdata <= {4'd0, level_c, high_c, cs_s2, out_s2, ds_s2};
		end
	end

endmodule
